FILE: src/cds_pkg.sv
package cds_pkg;

  // deck geometry
  localparam int DeckCards = 52;
  localparam int SuitRanks = 13;
  localparam int SuitCount = 4;
  localparam int WordBits  = 32;

  typedef logic [5:0] card_id_t;
  typedef logic [5:0] deck_pos_t;
  typedef logic [1:0] suit_t;
  typedef logic [3:0] rank_t;

  localparam deck_pos_t TopIndex = 6'(DeckCards - 1);

  // one write into the deck store
  typedef struct packed {
    logic      en;
    deck_pos_t addr;
    card_id_t  data;
  } deck_wr_t;

  // suit of a card id, suit-major order
  function automatic suit_t id_suit(input card_id_t id);
    suit_t s;
    if (id >= card_id_t'(3 * SuitRanks)) begin
      s = 2'd3;
    end else if (id >= card_id_t'(2 * SuitRanks)) begin
      s = 2'd2;
    end else if (id >= card_id_t'(SuitRanks)) begin
      s = 2'd1;
    end else begin
      s = 2'd0;
    end
    return s;
  endfunction

  // rank of a card id, ace is one
  function automatic rank_t id_rank(input card_id_t id);
    card_id_t base;
    card_id_t r;
    case (id_suit(id))
      2'd0:    base = card_id_t'(0);
      2'd1:    base = card_id_t'(SuitRanks);
      2'd2:    base = card_id_t'(2 * SuitRanks);
      2'd3:    base = card_id_t'(3 * SuitRanks);
      default: base = card_id_t'(0);
    endcase
    r = id - base + card_id_t'(1);
    return r[3:0];
  endfunction

endpackage

FILE: src/cds_if.sv
interface cds_req_if;
  import cds_pkg::*;
  logic                valid;
  logic                ready;
  logic                cmd;
  logic [WordBits-1:0] random_word;

  modport source (output valid, output cmd, output random_word, input ready);
  modport sink   (input valid, input cmd, input random_word, output ready);
endinterface

interface cds_rsp_if;
  import cds_pkg::*;
  logic      valid;
  logic      ready;
  deck_pos_t position;
  suit_t     card_suit;
  rank_t     card_rank;
  logic      last;

  modport source (output valid, output position, output card_suit, output card_rank,
                  output last, input ready);
  modport sink   (input valid, input position, input card_suit, input card_rank,
                  input last, output ready);
endinterface

FILE: src/card_deck_shuffler_unit.sv
// channel | dir | payload                                  | handshake
// req     | in  | cmd, random_word                         | valid/ready
// rsp     | out | position, card_suit, card_rank, last     | valid/ready
//
// a restore word leaves the block idle; req.ready is high only between items
// a shuffle word runs the bit-serial remainder (S_DIV), the registered read (S_READ)
// and the swap writes to slot i and slot j (S_WR_I, S_WR_J) before its first rsp word
// at position one a second word, slot zero marked last, follows through S_RD0 after the first is taken
// rst is synchronous; after it the deck reads as the ordered deck, top at 51
// a stalled rsp holds the block; no new req word is taken until all rsp go out
module card_deck_shuffler_unit
  import cds_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  cds_req_if.sink        req,
  cds_rsp_if.source      rsp
);

  typedef enum logic [2:0] {
    S_IDLE, S_DIV, S_READ, S_WR_I, S_WR_J, S_OUT1, S_RD0, S_OUT2
  } state_t;

  state_t    state;
  deck_pos_t top_pos;
  deck_pos_t pos;
  deck_pos_t j_idx;
  card_id_t  card_a;
  deck_pos_t eff_pos;
  logic      req_fire;
  logic      rem_start;
  logic      rem_done;
  deck_pos_t rem_val;
  deck_wr_t  deck_wr;
  deck_pos_t addr_b;
  card_id_t  rd_a;
  card_id_t  rd_b;
  logic      deck_clear;

  assign req.ready  = (state == S_IDLE);
  assign req_fire   = req.valid && req.ready;
  assign rem_start  = req_fire && req.cmd;
  assign deck_clear = req_fire && !req.cmd;

  // guard the counter range
  assign eff_pos = (top_pos < 6'd1 || top_pos > TopIndex) ? TopIndex : top_pos;

  cds_rem u_rem (
    .clk     (clk),
    .rst     (rst),
    .start   (rem_start),
    .word    (req.random_word),
    .modulus (eff_pos + 6'd1),
    .done    (rem_done),
    .rem     (rem_val)
  );

  // read port b moves to slot zero once the swap is written
  assign addr_b = (state == S_OUT1 || state == S_RD0) ? '0 : j_idx;

  // swap writes: slot i first, then slot j
  always_comb begin
    deck_wr = '0;
    case (state)
      S_WR_I: begin
        deck_wr.en   = 1'b1;
        deck_wr.addr = pos;
        deck_wr.data = rd_b;
      end
      S_WR_J: begin
        deck_wr.en   = 1'b1;
        deck_wr.addr = j_idx;
        deck_wr.data = card_a;
      end
      default: deck_wr = '0;
    endcase
  end

  cds_deck u_deck (
    .clk       (clk),
    .rst       (rst),
    .clear     (deck_clear),
    .wr        (deck_wr),
    .rd_addr_a (pos),
    .rd_addr_b (addr_b),
    .rd_data_a (rd_a),
    .rd_data_b (rd_b)
  );

  // sequencer and output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      top_pos   <= TopIndex;
      rsp.valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req_fire) begin
            if (req.cmd) begin
              pos   <= eff_pos;
              state <= S_DIV;
            end else begin
              top_pos <= TopIndex;
            end
          end
        end
        S_DIV: begin
          if (rem_done) begin
            j_idx <= rem_val;
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_WR_I;
        end
        S_WR_I: begin
          card_a        <= rd_a;
          rsp.position  <= pos;
          rsp.card_suit <= id_suit(rd_b);
          rsp.card_rank <= id_rank(rd_b);
          rsp.last      <= 1'b0;
          state         <= S_WR_J;
        end
        S_WR_J: begin
          rsp.valid <= 1'b1;
          top_pos   <= (pos == 6'd1) ? TopIndex : pos - 6'd1;
          state     <= S_OUT1;
        end
        S_OUT1: begin
          if (rsp.ready) begin
            rsp.valid <= 1'b0;
            state     <= (pos == 6'd1) ? S_RD0 : S_IDLE;
          end
        end
        S_RD0: begin
          rsp.position  <= '0;
          rsp.card_suit <= id_suit(rd_b);
          rsp.card_rank <= id_rank(rd_b);
          rsp.last      <= 1'b1;
          rsp.valid     <= 1'b1;
          state         <= S_OUT2;
        end
        S_OUT2: begin
          if (rsp.ready) begin
            rsp.valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // a word is shown only from the two output states
  a_valid_state: assert property (@(posedge clk) disable iff (rst)
      rsp.valid |-> (state == S_OUT1 || state == S_OUT2))
    else $error("rsp valid outside output state");
  // last marks slot zero only
  a_last_pos: assert property (@(posedge clk) disable iff (rst)
      (rsp.valid && rsp.last) |-> rsp.position == '0)
    else $error("last on a nonzero position");
  // the counter stays within the deck
  a_top_range: assert property (@(posedge clk) disable iff (rst)
      top_pos >= 6'd1 && top_pos <= TopIndex)
    else $error("top position out of range");
  // a shuffle word always starts the remainder unit
  a_shuffle_div: assert property (@(posedge clk) disable iff (rst)
      rem_start |=> state == S_DIV)
    else $error("shuffle did not start division");

endmodule

FILE: src/cds_rem.sv
module cds_rem
  import cds_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [WordBits-1:0] word,
  input  deck_pos_t           modulus,
  output logic                done,
  output deck_pos_t           rem
);

  logic [WordBits-1:0] shreg;
  deck_pos_t           mod_r;
  logic [4:0]          cnt;
  logic                busy;
  logic [6:0]          partial;
  logic [6:0]          diff;

  // one restoring step per cycle, word msb first
  assign partial = {rem, shreg[WordBits-1]};
  assign diff    = partial - {1'b0, mod_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'(WordBits - 1);
      end else if (busy) begin
        cnt <= cnt - 5'd1;
        if (cnt == 5'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= word;
      mod_r <= modulus;
      rem   <= '0;
    end else if (busy) begin
      shreg <= {shreg[WordBits-2:0], 1'b0};
      if (partial >= {1'b0, mod_r}) begin
        rem <= diff[5:0];
      end else begin
        rem <= partial[5:0];
      end
    end
  end

  // remainder is reduced when reported
  a_rem_range: assert property (@(posedge clk) disable iff (rst) done |-> rem < mod_r)
    else $error("remainder not below modulus");
  // done is a single pulse at the end of a run
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("done while still busy");
  // a run takes one busy step for each word bit before done is raised
  a_run_len: assert property (@(posedge clk) disable iff (rst)
      start |-> ##(WordBits + 1) done)
    else $error("remainder run length wrong");

endmodule

FILE: src/cds_deck.sv
module cds_deck
  import cds_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      clear,
  input  deck_wr_t  wr,
  input  deck_pos_t rd_addr_a,
  input  deck_pos_t rd_addr_b,
  output card_id_t  rd_data_a,
  output card_id_t  rd_data_b
);

  card_id_t            mem [DeckCards];
  logic [DeckCards-1:0] valid;
  card_id_t            raw_a;
  card_id_t            raw_b;
  logic                ok_a;
  logic                ok_b;
  deck_pos_t           addr_a_q;
  deck_pos_t           addr_b_q;

  // storage, one write and two registered reads
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    raw_a <= mem[rd_addr_a];
    raw_b <= mem[rd_addr_b];
  end

  // entry valid bits, an unwritten entry holds its ordered card
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      valid <= '0;
      ok_a  <= 1'b0;
      ok_b  <= 1'b0;
    end else begin
      if (wr.en) begin
        valid[wr.addr] <= 1'b1;
      end
      ok_a <= valid[rd_addr_a];
      ok_b <= valid[rd_addr_b];
    end
    addr_a_q <= rd_addr_a;
    addr_b_q <= rd_addr_b;
  end

  assign rd_data_a = ok_a ? raw_a : card_id_t'(addr_a_q);
  assign rd_data_b = ok_b ? raw_b : card_id_t'(addr_b_q);

endmodule

FILE: tb/sv/tb.sv
module tb;
  import cds_pkg::*;

  // command codes on the req channel
  localparam logic CmdRestore = 1'b0;
  localparam logic CmdShuffle = 1'b1;

  localparam int ItemTarget  = 1050;
  localparam int ResetCycles = 11;
  localparam int IdleLimit   = 1000;
  localparam int DrainCycles = 60;

  typedef struct packed {
    logic                cmd;
    logic [WordBits-1:0] word;
  } deck_cmd_t;

  typedef struct packed {
    deck_pos_t position;
    suit_t     card_suit;
    rank_t     card_rank;
    logic      last;
  } dealt_card_t;

  logic clk;
  logic rst;

  cds_req_if req_ch ();
  cds_rsp_if rsp_ch ();

  card_deck_shuffler_unit uut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  // clock, period 8
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // shadow deck and pass position
  card_id_t    deck_model [DeckCards];
  deck_pos_t   model_top;
  dealt_card_t expected_cards [$];

  deck_cmd_t pending_cmds [$];
  int        gen_pos;
  int        total_cmds;
  int        accepted_cmds;
  int        error_count;
  int        shuffle_count;
  int        restore_count;
  int        checked_cards;
  int        pass_count;

  function automatic void restore_model();
    for (int k = 0; k < DeckCards; k++) begin
      deck_model[k] = card_id_t'(k);
    end
    model_top = TopIndex;
  endfunction

  function automatic dealt_card_t card_at(input int pos, input logic fin);
    dealt_card_t c;
    int id;
    id = int'(deck_model[pos]);
    c.position  = deck_pos_t'(pos);
    c.card_suit = suit_t'(id / SuitRanks);
    c.card_rank = rank_t'(id % SuitRanks + 1);
    c.last      = fin;
    return c;
  endfunction

  // apply one accepted word to the shadow deck, queue the cards it reveals
  task automatic predict_cmd(input logic cmd, input logic [WordBits-1:0] word);
    int i;
    int j;
    logic [WordBits-1:0] modulus;
    card_id_t held;
    if (cmd == CmdRestore) begin
      restore_model();
      restore_count++;
    end else begin
      shuffle_count++;
      i = int'(model_top);
      // counter guard, out-of-range position acts as the top
      if (i < 1 || i > int'(TopIndex)) begin
        i = int'(TopIndex);
      end
      modulus = i + 1;
      j = int'(word % modulus);
      held = deck_model[i];
      deck_model[i] = deck_model[j];
      deck_model[j] = held;
      expected_cards.push_back(card_at(i, 1'b0));
      if (i == 1) begin
        expected_cards.push_back(card_at(0, 1'b1));
        model_top = TopIndex;
      end else begin
        model_top = deck_pos_t'(i - 1);
      end
    end
  endtask

  // stimulus side tracks the position so words can aim at the swap extremes
  function automatic logic [WordBits-1:0] pick_word();
    logic [WordBits-1:0] span;
    logic [WordBits-1:0] w;
    span = gen_pos + 1;
    case ($urandom_range(0, 5))
      0:       w = $urandom_range(0, 63);
      1:       w = 32'hFFFF_FFFF - $urandom_range(0, 63);
      2:       w = span * $urandom_range(0, 1000);             // swap with the bottom
      3:       w = span * $urandom_range(0, 1000) + span - 1;  // card stays put
      default: w = $urandom;
    endcase
    return w;
  endfunction

  task automatic add_cmd(input logic cmd, input logic [WordBits-1:0] word);
    deck_cmd_t c;
    c.cmd  = cmd;
    c.word = word;
    pending_cmds.push_back(c);
    if (cmd == CmdRestore || gen_pos == 1) begin
      gen_pos = TopIndex;
    end else begin
      gen_pos--;
    end
  endtask

  task automatic build_stimulus();
    int roll;
    int run;
    gen_pos = TopIndex;
    // directed: word extremes, swap with bottom and with itself, restores
    add_cmd(CmdShuffle, 32'h0000_0000);
    add_cmd(CmdShuffle, 32'hFFFF_FFFF);
    add_cmd(CmdShuffle, 32'd49);
    add_cmd(CmdShuffle, 32'h8000_0000);
    add_cmd(CmdShuffle, 32'h5555_5555);
    add_cmd(CmdShuffle, 32'hAAAA_AAAA);
    add_cmd(CmdRestore, 32'hFFFF_FFFF);
    add_cmd(CmdRestore, 32'h0000_0000);
    add_cmd(CmdShuffle, 32'd51);
    add_cmd(CmdShuffle, 32'd51);
    add_cmd(CmdShuffle, 32'h7FFF_FFFF);
    add_cmd(CmdRestore, 32'h1234_5678);
    // random: mostly long shuffle runs that wrap past position one
    while (pending_cmds.size() < ItemTarget) begin
      roll = $urandom_range(0, 99);
      if (roll < 75) begin
        run = $urandom_range(20, 110);
        repeat (run) add_cmd(CmdShuffle, pick_word());
      end else if (roll < 85) begin
        add_cmd(CmdRestore, $urandom);
      end else begin
        run = $urandom_range(1, 6);
        repeat (run) add_cmd(CmdShuffle, pick_word());
        add_cmd(CmdRestore, $urandom);
      end
    end
    total_cmds = pending_cmds.size();
  endtask

  // req driver, bursts with random gaps
  int        burst_left;
  int        gap_left;
  deck_cmd_t next_cmd;

  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid  <= 1'b0;
      burst_left    <= 0;
      gap_left      <= 0;
      accepted_cmds <= 0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        predict_cmd(req_ch.cmd, req_ch.random_word);
        accepted_cmds <= accepted_cmds + 1;
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (gap_left > 0) begin
          gap_left     <= gap_left - 1;
          req_ch.valid <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          next_cmd = pending_cmds.pop_front();
          req_ch.valid       <= 1'b1;
          req_ch.cmd         <= next_cmd.cmd;
          req_ch.random_word <= next_cmd.word;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 8);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // rsp monitor, ready follows a rotating pattern reloaded whenever the 7-bit tick wraps to zero
  logic [15:0] stall_pat;
  logic [15:0] stall_pat_n;
  logic [6:0]  stall_tick;
  dealt_card_t got_card;
  dealt_card_t want_card;

  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      stall_pat    <= 16'hFFFF;
      stall_tick   <= '0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        got_card.position  = rsp_ch.position;
        got_card.card_suit = rsp_ch.card_suit;
        got_card.card_rank = rsp_ch.card_rank;
        got_card.last      = rsp_ch.last;
        if (expected_cards.size() == 0) begin
          $display("%0t: unexpected word pos=%0d suit=%0d rank=%0d last=%0b", $time,
                   got_card.position, got_card.card_suit, got_card.card_rank, got_card.last);
          error_count++;
        end else begin
          want_card = expected_cards.pop_front();
          checked_cards++;
          if (want_card.last) begin
            pass_count++;
          end
          if (got_card !== want_card) begin
            $display("%0t: mismatch expected pos=%0d suit=%0d rank=%0d last=%0b", $time,
                     want_card.position, want_card.card_suit, want_card.card_rank,
                     want_card.last);
            $display("%0t:          actual   pos=%0d suit=%0d rank=%0d last=%0b", $time,
                     got_card.position, got_card.card_suit, got_card.card_rank,
                     got_card.last);
            error_count++;
          end
        end
      end
      if (stall_tick == '0) begin
        stall_pat_n = ($urandom_range(0, 2) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
      end else begin
        stall_pat_n = {stall_pat[0], stall_pat[15:1]};
      end
      stall_pat    <= stall_pat_n;
      stall_tick   <= stall_tick + 7'd1;
      rsp_ch.ready <= stall_pat_n[0];
    end
  end

  // watchdog on cycles with no word moving on either channel
  int idle_cycles;

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("%0t: timeout, no word moved for %0d cycles", $time, IdleLimit);
      $display("tb: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // reset, stimulus, end of run
  initial begin
    rst                = 1'b1;
    req_ch.valid       = 1'b0;
    req_ch.cmd         = CmdRestore;
    req_ch.random_word = '0;
    rsp_ch.ready       = 1'b0;
    error_count        = 0;
    shuffle_count      = 0;
    restore_count      = 0;
    checked_cards      = 0;
    pass_count         = 0;
    idle_cycles        = 0;
    restore_model();
    build_stimulus();
    repeat (ResetCycles) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (accepted_cmds < total_cmds) @(posedge clk);
    while (expected_cards.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (expected_cards.size() != 0) begin
      $display("%0t: %0d cards never dealt", $time, expected_cards.size());
      error_count++;
    end
    $display("run: %0d shuffle steps and %0d restores, %0d cards checked", shuffle_count,
             restore_count, checked_cards);
    $display("run: %0d complete shuffle passes, %0d errors", pass_count, error_count);
    if (error_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/cds_pkg.sv
src/cds_if.sv
src/cds_rem.sv
src/cds_deck.sv
src/card_deck_shuffler_unit.sv
tb/sv/tb.sv
